FILE: rtl/tec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helpers for the thermistor tolerance monitor.
// Used by tec_mul, tec_chk and the top level.

package tec_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;
  localparam int ADC_BITS = 10;
  localparam int TEMP_W   = 16;
  localparam int TOL_W    = 15;
  localparam int OPER_W   = 16;
  localparam int ACC_W    = 36;
  localparam int GAIN_W   = 26;
  localparam int CNT_W    = 3;

  localparam int RAW_DIGITS  = (ADC_BITS + 1) / 2;
  localparam int COMP_DIGITS = TEMP_W / 2;
  localparam int RAW_SHIFT   = ADC_BITS + 8;
  localparam int COMP_SHIFT  = 16;

  localparam logic signed [GAIN_W-1:0] RAW_GAIN   = -26'sd8114598;
  localparam logic signed [GAIN_W-1:0] RAW_GAIN3  = -26'sd24343794;
  localparam logic signed [GAIN_W-1:0] COMP_GAIN  = 26'sd72111;
  localparam logic signed [GAIN_W-1:0] COMP_GAIN3 = 26'sd216333;

  localparam logic signed [ACC_W-1:0] RAW_BIAS  = 36'sd4247972864;
  localparam logic signed [ACC_W-1:0] COMP_BIAS = -36'sd91204864;

  localparam logic signed [TEMP_W-1:0] SET_RESET  = 16'sd6400;
  localparam logic [TOL_W-1:0]         TOL_RESET  = 15'd256;
  localparam logic signed [TEMP_W-1:0] DISC_RESET = -16'sd10240;

  typedef enum logic [2:0] {
    REG_SET_PUMP1    = 3'd0,
    REG_SET_PUMP2    = 3'd1,
    REG_SET_VANADATE = 3'd2,
    REG_SET_KTP      = 3'd3,
    REG_TOL_PUMP     = 3'd4,
    REG_TOL_VANADATE = 3'd5,
    REG_TOL_KTP      = 3'd6,
    REG_DISC_LIMIT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic step;
    logic first_signed;
  } mul_ctl_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic                     armed;
    logic signed [TEMP_W-1:0] raw;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] set_temp;
    logic [TOL_W-1:0]         tol;
    logic signed [TEMP_W-1:0] disc_limit;
  } chk_in_t;

  function automatic logic signed [TEMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = 36'sd32767;
    lo = -36'sd32768;
    if (v > hi) begin
      sat16 = 16'sh7fff;
    end else if (v < lo) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[TEMP_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tec_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Digit-serial constant multiplier, two multiplier bits per cycle while ctl.step is set, MSB first.
// Depends on tec_pkg.

module tec_mul
  import tec_pkg::*;
(
  input  wire logic                     clk,
  input  wire mul_ctl_t                 ctl,
  input  wire logic [OPER_W-1:0]        oper,
  input  wire logic signed [GAIN_W-1:0] gain,
  input  wire logic signed [GAIN_W-1:0] gain3,
  output logic signed [ACC_W-1:0]       prod
);

  logic [OPER_W-1:0]       mreg;
  logic                    first;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] g1;
  logic signed [ACC_W-1:0] g2;
  logic signed [ACC_W-1:0] g3;
  logic signed [ACC_W-1:0] pp;
  logic [1:0]              digit;

  assign digit = mreg[OPER_W-1 -: 2];
  assign g1    = ACC_W'(gain);
  assign g2    = g1 <<< 1;
  assign g3    = ACC_W'(gain3);
  assign prod  = acc;

  always_comb begin
    case ({first, digit})
      3'b001:  pp = g1;
      3'b010:  pp = g2;
      3'b011:  pp = g3;
      3'b101:  pp = g1;
      3'b110:  pp = -g2;
      3'b111:  pp = -g1;
      default: pp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mreg  <= oper;
      first <= ctl.first_signed;
      acc   <= '0;
    end else if (ctl.step) begin
      mreg  <= mreg << 2;
      first <= 1'b0;
      acc   <= (acc <<< 2) + pp;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tec_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-channel tolerance check with hysteresis, detach handling and state flags.
// Depends on tec_pkg.

module tec_chk
  import tec_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    update,
  input  wire chk_in_t req,
  output logic         ok,
  output logic         all
);

  logic [CHANNELS-1:0] ever_valid, ever_valid_next;
  logic [CHANNELS-1:0] out_of_band, out_of_band_next;
  logic [CHANNELS-1:0] latest_ok, latest_ok_next;

  logic signed [TEMP_W:0] diff;
  logic [TEMP_W-1:0]      err;
  logic [TEMP_W:0]        err2;
  logic                   inb;
  logic                   oob;
  logic                   in_range;

  assign diff = {req.set_temp[TEMP_W-1], req.set_temp}
              - {req.temp[TEMP_W-1], req.temp};
  assign err  = diff[TEMP_W] ? TEMP_W'(-diff) : diff[TEMP_W-1:0];
  assign err2 = {err, 1'b0};
  assign inb  = err < TEMP_W'(req.tol);
  assign in_range = int'(req.channel) < CHANNELS;

  always_comb begin
    ever_valid_next  = ever_valid;
    out_of_band_next = out_of_band;
    latest_ok_next   = latest_ok;
    ok               = 1'b0;
    oob              = out_of_band[req.channel];
    if (in_range) begin
      if (req.raw < req.disc_limit && !ever_valid[req.channel]) begin
        out_of_band_next[req.channel] = 1'b0;
        ok = 1'b1;
      end else begin
        if (req.armed) begin
          ever_valid_next[req.channel] = 1'b1;
        end
        if (oob && err2 < (TEMP_W+1)'(req.tol)) begin
          oob = 1'b0;
        end
        if (!inb) begin
          oob = 1'b1;
        end
        out_of_band_next[req.channel] = oob;
        ok = inb && !oob;
      end
      latest_ok_next[req.channel] = ok;
    end
    all = &latest_ok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ever_valid  <= '0;
      out_of_band <= '0;
      latest_ok   <= '0;
    end else if (update) begin
      ever_valid  <= ever_valid_next;
      out_of_band <= out_of_band_next;
      latest_ok   <= latest_ok_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tec_temperature_tolerance_monitor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the thermistor tolerance monitor: configuration registers,
// sequencer and output register. Depends on tec_pkg, tec_mul and tec_chk.

// Each accepted word passes through RAW_MUL, RAW_FIN, COMP_MUL, COMP_FIN and
// CHECK before its result is loaded into the output register, and the next word
// can be accepted in the cycle after that load, not while a word is in flight.
// The shared digit-serial multiplier retires two multiplier bits per cycle: five
// digits for the ADC code, eight for the raw temperature. A result waiting in
// the output register does not block the next word; only a new result waits in
// the check state for the register to free up.

module tec_temperature_tolerance_monitor_top
  import tec_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [CH_W-1:0]        channel,
  input  wire logic [ADC_BITS-1:0]    adc_code,
  input  wire logic                   uptime_armed,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [TEMP_W-1:0]    temp_c,
  output logic                        channel_ok,
  output logic                        all_ok,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [TEMP_W-1:0]      cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_RAW_MUL  = 6'b000010,
    ST_RAW_FIN  = 6'b000100,
    ST_COMP_MUL = 6'b001000,
    ST_COMP_FIN = 6'b010000,
    ST_CHECK    = 6'b100000
  } state_t;

  state_t state, state_next;

  logic signed [TEMP_W-1:0] set_temp [CHANNELS];
  logic [TOL_W-1:0]         tol_pump, tol_vanadate, tol_ktp;
  logic signed [TEMP_W-1:0] disc_limit;

  logic [CH_W-1:0]          ch_r;
  logic                     armed_r;
  logic signed [TEMP_W-1:0] raw_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [CNT_W-1:0]         cnt, cnt_next;

  mul_ctl_t                 mctl;
  logic [OPER_W-1:0]        moper;
  logic signed [GAIN_W-1:0] mgain, mgain3;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  raw_sum, comp_sum;
  logic signed [TEMP_W-1:0] raw_val, temp_val;

  chk_in_t                  creq;
  logic                     c_ok, c_all;
  logic                     accept, out_free, out_load;
  logic [TOL_W-1:0]         tol_sel;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = state == ST_CHECK && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        set_temp[i] <= SET_RESET;
      end
      tol_pump     <= TOL_RESET;
      tol_vanadate <= TOL_RESET;
      tol_ktp      <= TOL_RESET;
      disc_limit   <= DISC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SET_PUMP1:    set_temp[0]  <= cfg_data;
        REG_SET_PUMP2:    set_temp[1]  <= cfg_data;
        REG_SET_VANADATE: set_temp[2]  <= cfg_data;
        REG_SET_KTP:      set_temp[3]  <= cfg_data;
        REG_TOL_PUMP:     tol_pump     <= cfg_data[TOL_W-1:0];
        REG_TOL_VANADATE: tol_vanadate <= cfg_data[TOL_W-1:0];
        REG_TOL_KTP:      tol_ktp      <= cfg_data[TOL_W-1:0];
        REG_DISC_LIMIT:   disc_limit   <= cfg_data;
        default:          disc_limit   <= disc_limit;
      endcase
    end
  end

  assign raw_sum  = prod + RAW_BIAS;
  assign comp_sum = prod + COMP_BIAS;
  assign raw_val  = sat16(raw_sum >>> RAW_SHIFT);
  assign temp_val = sat16(comp_sum >>> COMP_SHIFT);

  always_comb begin
    mctl       = '0;
    moper      = OPER_W'(adc_code) << (OPER_W - 2 * RAW_DIGITS);
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mctl.load  = 1'b1;
          cnt_next   = '0;
          state_next = ST_RAW_MUL;
        end
      end
      ST_RAW_MUL: begin
        mctl.step = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_W'(RAW_DIGITS - 1)) begin
          state_next = ST_RAW_FIN;
        end
      end
      ST_RAW_FIN: begin
        mctl.load         = 1'b1;
        mctl.first_signed = 1'b1;
        moper             = raw_val;
        cnt_next          = '0;
        state_next        = ST_COMP_MUL;
      end
      ST_COMP_MUL: begin
        mctl.step = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_W'(COMP_DIGITS - 1)) begin
          state_next = ST_COMP_FIN;
        end
      end
      ST_COMP_FIN: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign mgain  = (state == ST_RAW_MUL) ? RAW_GAIN : COMP_GAIN;
  assign mgain3 = (state == ST_RAW_MUL) ? RAW_GAIN3 : COMP_GAIN3;

  tec_mul u_mul (
    .clk   (clk),
    .ctl   (mctl),
    .oper  (moper),
    .gain  (mgain),
    .gain3 (mgain3),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r    <= channel;
      armed_r <= uptime_armed;
    end
    if (state == ST_RAW_FIN) begin
      raw_r <= raw_val;
    end
    if (state == ST_COMP_FIN) begin
      temp_r <= temp_val;
    end
  end

  always_comb begin
    if (ch_r < CH_W'(2)) begin
      tol_sel = tol_pump;
    end else if (ch_r == CH_W'(2)) begin
      tol_sel = tol_vanadate;
    end else begin
      tol_sel = tol_ktp;
    end
  end

  always_comb begin
    creq.channel    = ch_r;
    creq.armed      = armed_r;
    creq.raw        = raw_r;
    creq.temp       = temp_r;
    creq.set_temp   = set_temp[ch_r];
    creq.tol        = tol_sel;
    creq.disc_limit = disc_limit;
  end

  tec_chk u_chk (
    .clk    (clk),
    .rst    (rst),
    .update (out_load),
    .req    (creq),
    .ok     (c_ok),
    .all    (c_all)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      temp_c     <= temp_r;
      channel_ok <= c_ok;
      all_ok     <= c_all;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_RAW_MUL)
    else $error("accepted word did not start the code multiply");

  a_all_implies_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && all_ok |-> channel_ok)
    else $error("all_ok set while this channel is out of tolerance");

  a_raw_digits: assert property (@(posedge clk) disable iff (rst)
    state == ST_RAW_MUL |-> cnt < CNT_W'(RAW_DIGITS))
    else $error("digit counter overran the code multiply");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && out_stall))
    else $error("result loaded over a word still waiting at the output");

endmodule

`default_nettype wire
